>>> src/kr_pkg.sv
// Shared types, constants and the fn translation table for the key report event unit.
`timescale 1ns / 1ps
package kr_pkg;

    localparam int KEY_SLOTS = 6;
    localparam int MOD_BITS  = 8;
    localparam int SET_SIZE  = KEY_SLOTS + MOD_BITS;
    localparam int EV_CNT    = 2 * SET_SIZE;

    localparam logic [7:0] MOD_BASE = 8'd84;
    localparam logic [7:0] FN_BASE  = 8'd93;

    typedef logic [7:0] t_code;
    typedef logic [SET_SIZE-1:0][7:0] t_set;
    typedef logic [EV_CNT-1:0][7:0] t_ev_codes;

    // per-lane findings
    typedef struct packed {
        logic up;
        logic down;
    } t_lane_res;

    // load request from the control FSM to the event walker
    typedef struct packed {
        logic load;
        logic fn;
    } t_emit_ctl;

    // fn layer: returns 0 where the code has no fn meaning
    function automatic t_code fn_translate(input t_code c);
        t_code r;
        if (c >= 8'd79 && c <= 8'd82) begin
            r = FN_BASE + (c - 8'd79);
        end else if (c == 8'd40) begin
            r = FN_BASE + 8'd5;
        end else if (c == 8'd58 || c == 8'd59) begin
            r = FN_BASE + 8'd6 + (c - 8'd58);
        end else if (c >= 8'd62 && c <= 8'd69) begin
            r = FN_BASE + 8'd8 + (c - 8'd62);
        end else begin
            r = 8'd0;
        end
        return r;
    endfunction

endpackage

>>> src/kr_if.sv
// Handshake interfaces for the report input, event output and config write channels.
`timescale 1ns / 1ps
interface kr_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] msg_type;
    logic [7:0]  key_0;
    logic [7:0]  key_1;
    logic [7:0]  key_2;
    logic [7:0]  key_3;
    logic [7:0]  key_4;
    logic [7:0]  key_5;
    logic [7:0]  modifier_mask;
    logic        fn_held;
    logic        overflow;

    modport source (output valid, msg_type, key_0, key_1, key_2, key_3, key_4, key_5,
                    modifier_mask, fn_held, overflow, input ready);
    modport sink   (input valid, msg_type, key_0, key_1, key_2, key_3, key_4, key_5,
                    modifier_mask, fn_held, overflow, output ready);
endinterface

interface kr_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] key_code;
    logic       pressed;
    logic       last;

    modport source (output valid, key_code, pressed, last, input ready);
    modport sink   (input valid, key_code, pressed, last, output ready);
endinterface

interface kr_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] data_type_code;

    modport source (output valid, data_type_code, input ready);
    modport sink   (input valid, data_type_code, output ready);
endinterface

>>> src/key_report_diff_events_unit.sv
// Top level: report capture, held-code state, compare lanes and event walker.
// Flow: an accepted report is captured, then compared against the held codes, and the event
//   walker steps through the 28 event slots into the output register, one walk slot per cycle.
// A new report is taken only once the event walk of the last one is done;
//   ignored reports are dropped in the accept cycle. Output stalls pause the walk.
// Reset (synchronous, active low) clears the held codes, the type register and all control.
`timescale 1ns / 1ps
module key_report_diff_events_unit (
    input  logic     i_clk,
    input  logic     i_rst_n,
    kr_in_if.sink    i_in,
    kr_out_if.source o_out,
    kr_cfg_if.sink   i_cfg
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CALC,
        S_EMIT
    } t_state;

    t_state        r_state;
    logic [15:0]   r_dtc;
    kr_pkg::t_set  r_held;
    kr_pkg::t_set  r_now;
    logic          r_fn;

    kr_pkg::t_set              n_now;
    logic                      in_take;
    logic                      in_match;
    kr_pkg::t_lane_res         lane_res [kr_pkg::SET_SIZE];
    logic [kr_pkg::EV_CNT-1:0] ev_mask;
    kr_pkg::t_ev_codes         ev_codes;
    kr_pkg::t_emit_ctl         emit_ctl;
    logic                      emit_busy;

    assign i_in.ready  = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign in_take     = i_in.valid && i_in.ready;
    assign in_match    = (i_in.msg_type == r_dtc) && !i_in.overflow;

    // code set of the incoming report: slots, then one entry per modifier bit
    always_comb begin
        n_now[0] = i_in.key_0;
        n_now[1] = i_in.key_1;
        n_now[2] = i_in.key_2;
        n_now[3] = i_in.key_3;
        n_now[4] = i_in.key_4;
        n_now[5] = i_in.key_5;
        for (int i = 0; i < kr_pkg::MOD_BITS; i++) begin
            n_now[kr_pkg::KEY_SLOTS + i] = i_in.modifier_mask[i] ?
                (kr_pkg::MOD_BASE + 8'(i)) : 8'd0;
        end
    end

    // control FSM, config register and held-code state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_dtc   <= 16'd0;
            r_held  <= '0;
        end else begin
            if (i_cfg.valid) r_dtc <= i_cfg.data_type_code;
            unique case (r_state)
                S_IDLE: begin
                    if (in_take && in_match) r_state <= S_CALC;
                end
                S_CALC: begin
                    r_held  <= r_now;
                    r_state <= S_EMIT;
                end
                S_EMIT: begin
                    if (!emit_busy) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // captured report
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_now <= n_now;
            r_fn  <= i_in.fn_held;
        end
    end

    // compare lanes, one per set entry
    for (genvar g = 0; g < kr_pkg::SET_SIZE; g++) begin : g_lane
        kr_lane u_lane (
            .i_held_c   (r_held[g]),
            .i_now_c    (r_now[g]),
            .i_held_set (r_held),
            .i_now_set  (r_now),
            .i_fn       (r_fn),
            .o_res      (lane_res[g])
        );
        assign ev_mask[g]                   = lane_res[g].up;
        assign ev_mask[kr_pkg::SET_SIZE + g] = lane_res[g].down;
        assign ev_codes[g]                  = r_held[g];
        assign ev_codes[kr_pkg::SET_SIZE + g] = r_now[g];
    end

    assign emit_ctl.load = (r_state == S_CALC);
    assign emit_ctl.fn   = r_fn;

    kr_emit u_emit (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (emit_ctl),
        .i_mask  (ev_mask),
        .i_codes (ev_codes),
        .o_busy  (emit_busy),
        .o_out   (o_out)
    );

endmodule

>>> src/kr_lane.sv
// One compare lane: flags a held code that was released and a new code that was pressed.
`timescale 1ns / 1ps
module kr_lane (
    input  kr_pkg::t_code     i_held_c,
    input  kr_pkg::t_code     i_now_c,
    input  kr_pkg::t_set      i_held_set,
    input  kr_pkg::t_set      i_now_set,
    input  logic              i_fn,
    output kr_pkg::t_lane_res o_res
);

    logic held_in_now;
    logic now_in_held;

    // membership search across the other set
    always_comb begin
        held_in_now = 1'b0;
        now_in_held = 1'b0;
        for (int j = 0; j < kr_pkg::SET_SIZE; j++) begin
            if (i_now_set[j] == i_held_c) held_in_now = 1'b1;
            if (i_held_set[j] == i_now_c) now_in_held = 1'b1;
        end
    end

    // key-up always goes out; key-down under fn needs a translation
    always_comb begin
        o_res.up   = (i_held_c != 8'd0) && !held_in_now;
        o_res.down = (i_now_c != 8'd0) && !now_in_held &&
                     (!i_fn || (kr_pkg::fn_translate(i_now_c) != 8'd0));
    end

endmodule

>>> src/kr_emit.sv
// Merge stage: drives the output; walks lane flags a slot a cycle, flagged ones wait till it is free.
`timescale 1ns / 1ps
module kr_emit (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  kr_pkg::t_emit_ctl       i_ctl,
    input  logic [kr_pkg::EV_CNT-1:0] i_mask,
    input  kr_pkg::t_ev_codes       i_codes,
    output logic                    o_busy,
    kr_out_if.source                o_out
);

    logic [kr_pkg::EV_CNT-1:0] r_mask;
    logic [kr_pkg::EV_CNT-1:0] r_dir;
    kr_pkg::t_ev_codes         r_codes;
    logic                      r_fn;
    logic                      r_ovalid;
    kr_pkg::t_code             r_ocode;
    logic                      r_opress;
    logic                      r_olast;

    logic          out_free;
    logic          step;
    logic          fire;
    kr_pkg::t_code tr_code;
    kr_pkg::t_code ev_code;

    assign out_free = !r_ovalid || o_out.ready;
    assign step     = (r_mask != '0) && (!r_mask[0] || out_free);
    assign fire     = step && r_mask[0];
    assign o_busy   = (r_mask != '0);

    // fn translation of the slot at the head of the walk
    always_comb begin
        tr_code = kr_pkg::fn_translate(r_codes[0]);
        ev_code = (r_fn && (tr_code != 8'd0)) ? tr_code : r_codes[0];
    end

    // walk control and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mask   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_ctl.load) begin
                r_mask <= i_mask;
            end else if (step) begin
                r_mask <= r_mask >> 1;
            end
            if (fire) begin
                r_ovalid <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // payload: slot codes, direction bits and the output word
    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_codes <= i_codes;
            r_dir   <= {{kr_pkg::SET_SIZE{1'b1}}, {kr_pkg::SET_SIZE{1'b0}}};
            r_fn    <= i_ctl.fn;
        end else if (step) begin
            r_codes <= {8'd0, r_codes[kr_pkg::EV_CNT-1:1]};
            r_dir   <= r_dir >> 1;
        end
        if (fire) begin
            r_ocode  <= ev_code;
            r_opress <= r_dir[0];
            r_olast  <= (r_mask[kr_pkg::EV_CNT-1:1] == '0);
        end
    end

    assign o_out.valid    = r_ovalid;
    assign o_out.key_code = r_ocode;
    assign o_out.pressed  = r_opress;
    assign o_out.last     = r_olast;

endmodule

>>> src/kr_chk.sv
// Port-level checker for the key report event unit, with its bind.
`timescale 1ns / 1ps
module kr_chk (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       i_in_ready,
    input logic       i_out_valid,
    input logic       i_out_ready,
    input logic [7:0] i_out_code,
    input logic       i_out_pressed,
    input logic       i_out_last
);

    // a stalled event word holds
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_code) &&
        $stable(i_out_pressed) && $stable(i_out_last))
        else $error("event word changed under stall");

    // no event ever carries the empty code
    a_code_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> i_out_code != 8'd0)
        else $error("event with empty key code");

    // once idle, a pending event can only be the last of its report
    a_idle_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_ready && i_out_valid |-> i_out_last)
        else $error("input taken while report events remain");

    // reset leaves no event pending
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("event valid after reset");

endmodule

bind key_report_diff_events_unit kr_chk u_kr_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_ready    (i_in.ready),
    .i_out_valid   (o_out.valid),
    .i_out_ready   (o_out.ready),
    .i_out_code    (o_out.key_code),
    .i_out_pressed (o_out.pressed),
    .i_out_last    (o_out.last)
);
